### sv/lpmf_pkg.sv
package lpmf_pkg;

    localparam int DEPTH     = 1024;
    localparam int HDR_BYTES = 2;
    localparam int POS_W     = $clog2(DEPTH);
    localparam int RING_W    = $clog2(DEPTH + 1);
    localparam int LEN_W     = 10;
    localparam int CFG_W     = 11;
    localparam int HDR_W     = 8 * HDR_BYTES;
    localparam int HCNT_W    = $clog2(HDR_BYTES + 1);
    localparam int MIN_RING  = 16;

    typedef enum logic [1:0] {
        FN_WR_BEGIN = 2'd0,
        FN_WR_DATA  = 2'd1,
        FN_RD_BEGIN = 2'd2,
        FN_RD_NEXT  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_TOO_SMALL = 3'd3,
        ST_SEQ       = 3'd4
    } status_t;

    typedef struct packed {
        func_t            func;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] capacity;
        logic [7:0]       data_byte;
    } item_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [LEN_W-1:0] length_res;
        logic [7:0]       data_byte_res;
        logic             last;
    } result_t;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [POS_W-1:0] addr;
        logic [7:0]       wdata;
    } ram_req_t;

    // next ring position, wrapping at the ring size in use
    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                 input logic [RING_W-1:0] ring);
        logic [RING_W-1:0] nxt;
        nxt = RING_W'(pos) + RING_W'(1);
        return (nxt >= ring) ? '0 : POS_W'(nxt);
    endfunction

endpackage

### sv/length_prefixed_message_fifo_unit.sv
// Byte ring of up to DEPTH bytes holding whole messages, each stored as a
// little-endian length header of HDR_BYTES bytes followed by its data.
// All message bytes live in one single-port byte memory with a registered
// read, so every request makes at most one memory access per cycle and
// reads and writes never overlap. A write data byte, or any request
// answered by status alone (full, empty, sequence error), is answered
// from the idle state; read next byte waits in S_RD_WAIT for the memory
// read; write_begin writes its HDR_BYTES header bytes one per cycle;
// read_begin reads the header bytes one per cycle, then waits for the
// last read. The result sits in an output register; a new request
// is taken only in the idle state and when that register is empty or its
// result is taken on m_tready in the same cycle.
// A configuration write sets the ring size (clamped to 16..DEPTH) and
// empties the ring; the byte memory needs no clearing pass after reset.
module length_prefixed_message_fifo_unit
    import lpmf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration: buffer_bytes
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // length[9:0], capacity[19:10], data_byte[27:20]
    input  logic [1:0]       s_tuser,   // func[1:0]
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // length_res[9:0], data_byte_res[17:10]
    output logic [2:0]       m_tuser,   // status[2:0]
    output logic             m_tlast    // last
);

    // ring size in use, clamped copy of buffer_bytes
    logic [RING_W-1:0] ring_reg;

    // output register
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;
    logic [2:0]        m_user_reg;
    logic              m_last_reg;

    logic              out_free;
    item_t             item;
    result_t           res;
    ram_req_t          ram_req;
    logic [7:0]        ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= RING_W'(DEPTH);
        end else if (cfg_wr_en) begin
            priority if (cfg_wr_data < CFG_W'(MIN_RING)) begin
                ring_reg <= RING_W'(MIN_RING);
            end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
                ring_reg <= RING_W'(DEPTH);
            end else begin
                ring_reg <= RING_W'(cfg_wr_data);
            end
        end
    end

    // unpack the request payload
    assign item.func      = func_t'(s_tuser);
    assign item.length    = s_tdata[9:0];
    assign item.capacity  = s_tdata[19:10];
    assign item.data_byte = s_tdata[27:20];

    // the result register is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_tready;

    lpmf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_wr_en),
        .ring_size (ring_reg),
        .in_valid  (s_tvalid),
        .item      (item),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    lpmf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_data_reg <= {6'b0, res.data_byte_res, res.length_res};
            m_user_reg <= res.status;
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> out_free)
        else $error("result register overwritten");

    // a request is taken only while the result register can accept a new result
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !res.valid || out_free)
        else $error("request taken with result register busy");

    // a read next byte that was taken returns its byte on the following cycle
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn || cfg_wr_en)
        (s_tvalid && s_tready && s_tuser == FN_RD_NEXT && ram_req.en) |=>
            (res.valid && res.status == ST_OK))
        else $error("read byte not returned after memory latency");

    // a sequence error never closes a message
    a_seq_no_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.status == ST_SEQ) |-> !res.last)
        else $error("sequence error marked as last");

endmodule

### sv/lpmf_ram.sv
module lpmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lpmf_ctrl.sv
module lpmf_ctrl
    import lpmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic [RING_W-1:0] ring_size,
    input  logic              in_valid,
    input  item_t             item,
    input  logic              out_free,
    output logic              in_ready,
    output result_t           res,
    output ram_req_t          ram_req,
    input  logic [7:0]        ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_HDR_WR  = 4'b0010,
        S_HDR_RD  = 4'b0100,
        S_RD_WAIT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [POS_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [POS_W-1:0]  com_pos_reg, com_pos_next;
    logic [LEN_W-1:0]  wr_left_reg, wr_left_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic [POS_W-1:0]  hdr_addr_reg, hdr_addr_next;
    logic [HCNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [HCNT_W-1:0] rcv_cnt_reg, rcv_cnt_next;
    logic [HDR_W-1:0]  hdr_sh_reg, hdr_sh_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;
    logic              last_reg, last_next;

    logic              accept;
    logic [RING_W:0]   free_raw;
    logic [RING_W:0]   free_b;
    logic [RING_W:0]   need_b;
    logic              fits_hdr;
    logic [HDR_W-1:0]  hdr_in;
    logic [LEN_W-1:0]  stored;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // free bytes, one byte always kept open
    assign free_raw = (RING_W+1)'(rd_pos_reg) + (RING_W+1)'(ring_size)
                    - (RING_W+1)'(wr_pos_reg) - (RING_W+1)'(1);
    assign free_b   = (free_raw >= (RING_W+1)'(ring_size))
                    ? free_raw - (RING_W+1)'(ring_size) : free_raw;
    assign need_b   = (RING_W+1)'(HDR_BYTES) + (RING_W+1)'(item.length);
    assign fits_hdr = (HDR_BYTES >= 2) || (item.length < LEN_W'(256));

    // header bytes arrive lowest first and shift in from the top
    assign hdr_in   = HDR_W'({ram_rdata, hdr_sh_reg} >> 8);
    assign stored   = LEN_W'(hdr_in);

    always_comb begin
        state_next    = state_reg;
        rd_pos_next   = rd_pos_reg;
        wr_pos_next   = wr_pos_reg;
        com_pos_next  = com_pos_reg;
        wr_left_next  = wr_left_reg;
        rd_left_next  = rd_left_reg;
        hdr_addr_next = hdr_addr_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        rcv_cnt_next  = rcv_cnt_reg;
        hdr_sh_next   = hdr_sh_reg;
        cap_next      = cap_reg;
        last_next     = last_reg;
        res           = '0;
        res.status    = ST_OK;
        ram_req       = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res.valid = 1'b1;
                    unique case (item.func)
                        FN_WR_BEGIN: begin
                            if (wr_left_reg != '0) begin
                                res.status = ST_SEQ;
                            end else if (!fits_hdr || need_b > free_b) begin
                                res.status = ST_FULL;
                            end else begin
                                ram_req.en    = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.addr  = wr_pos_reg;
                                ram_req.wdata = item.length[7:0];
                                wr_pos_next   = advance(wr_pos_reg, ring_size);
                                wr_left_next  = item.length;
                                hdr_sh_next   = HDR_W'(item.length) >> 8;
                                hdr_cnt_next  = HCNT_W'(1);
                                res.last      = (item.length == '0);
                                if (HDR_BYTES == 1) begin
                                    if (item.length == '0) begin
                                        com_pos_next = advance(wr_pos_reg, ring_size);
                                    end
                                end else begin
                                    state_next = S_HDR_WR;
                                end
                            end
                        end
                        FN_WR_DATA: begin
                            if (wr_left_reg == '0) begin
                                res.status = ST_SEQ;
                            end else begin
                                ram_req.en    = 1'b1;
                                ram_req.we    = 1'b1;
                                ram_req.addr  = wr_pos_reg;
                                ram_req.wdata = item.data_byte;
                                wr_pos_next   = advance(wr_pos_reg, ring_size);
                                wr_left_next  = wr_left_reg - LEN_W'(1);
                                if (wr_left_reg == LEN_W'(1)) begin
                                    com_pos_next = advance(wr_pos_reg, ring_size);
                                    res.last     = 1'b1;
                                end
                            end
                        end
                        FN_RD_BEGIN: begin
                            if (rd_left_reg != '0) begin
                                res.status = ST_SEQ;
                            end else if (rd_pos_reg == com_pos_reg) begin
                                res.status = ST_EMPTY;
                            end else begin
                                // answer comes at the end of the header read
                                res.valid     = 1'b0;
                                ram_req.en    = 1'b1;
                                ram_req.addr  = rd_pos_reg;
                                hdr_addr_next = advance(rd_pos_reg, ring_size);
                                hdr_cnt_next  = HCNT_W'(1);
                                rcv_cnt_next  = '0;
                                cap_next      = item.capacity;
                                state_next    = S_HDR_RD;
                            end
                        end
                        FN_RD_NEXT: begin
                            if (rd_left_reg == '0) begin
                                res.status = ST_SEQ;
                            end else begin
                                res.valid    = 1'b0;
                                ram_req.en   = 1'b1;
                                ram_req.addr = rd_pos_reg;
                                rd_pos_next  = advance(rd_pos_reg, ring_size);
                                rd_left_next = rd_left_reg - LEN_W'(1);
                                last_next    = (rd_left_reg == LEN_W'(1));
                                state_next   = S_RD_WAIT;
                            end
                        end
                        default: begin
                            res.status = ST_SEQ;
                        end
                    endcase
                end
            end
            S_HDR_WR: begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = wr_pos_reg;
                ram_req.wdata = hdr_sh_reg[7:0];
                wr_pos_next   = advance(wr_pos_reg, ring_size);
                hdr_sh_next   = hdr_sh_reg >> 8;
                hdr_cnt_next  = hdr_cnt_reg + HCNT_W'(1);
                if (hdr_cnt_reg == HCNT_W'(HDR_BYTES - 1)) begin
                    state_next = S_IDLE;
                    if (wr_left_reg == '0) begin
                        com_pos_next = advance(wr_pos_reg, ring_size);
                    end
                end
            end
            S_HDR_RD: begin
                if (hdr_cnt_reg != HCNT_W'(HDR_BYTES)) begin
                    ram_req.en    = 1'b1;
                    ram_req.addr  = hdr_addr_reg;
                    hdr_addr_next = advance(hdr_addr_reg, ring_size);
                    hdr_cnt_next  = hdr_cnt_reg + HCNT_W'(1);
                end
                hdr_sh_next  = hdr_in;
                rcv_cnt_next = rcv_cnt_reg + HCNT_W'(1);
                if (rcv_cnt_reg == HCNT_W'(HDR_BYTES - 1)) begin
                    state_next     = S_IDLE;
                    res.valid      = 1'b1;
                    res.length_res = stored;
                    if (stored > cap_reg) begin
                        // message stays put, read position untouched
                        res.status = ST_TOO_SMALL;
                    end else begin
                        rd_pos_next  = hdr_addr_reg;
                        rd_left_next = stored;
                        res.last     = (stored == '0);
                    end
                end
            end
            S_RD_WAIT: begin
                res.valid         = 1'b1;
                res.data_byte_res = ram_rdata;
                res.last          = last_reg;
                state_next        = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            state_reg   <= S_IDLE;
            rd_pos_reg  <= '0;
            wr_pos_reg  <= '0;
            com_pos_reg <= '0;
            wr_left_reg <= '0;
            rd_left_reg <= '0;
        end else begin
            state_reg   <= state_next;
            rd_pos_reg  <= rd_pos_next;
            wr_pos_reg  <= wr_pos_next;
            com_pos_reg <= com_pos_next;
            wr_left_reg <= wr_left_next;
            rd_left_reg <= rd_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_addr_reg <= hdr_addr_next;
        hdr_cnt_reg  <= hdr_cnt_next;
        rcv_cnt_reg  <= rcv_cnt_next;
        hdr_sh_reg   <= hdr_sh_next;
        cap_reg      <= cap_next;
        last_reg     <= last_next;
    end

endmodule

### tb/length_prefixed_message_fifo_unit_test.sv
`timescale 1ns / 1ps

module length_prefixed_message_fifo_unit_test;
    import lpmf_pkg::*;

    // idle cycles allowed before a config write, and the hang limit
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 40;
    localparam int MAX_PRINTS    = 40;

    // one response as the checker sees it
    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] len;
        logic [7:0]       rbyte;
        logic             last;
    } resp_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata     = '0;   // length[9:0], capacity[19:10], data_byte[27:20]
    logic [1:0]       s_tuser     = '0;   // func[1:0]
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [23:0]      m_tdata;            // length_res[9:0], data_byte_res[17:10]
    logic [2:0]       m_tuser;            // status[2:0]
    logic             m_tlast;

    length_prefixed_message_fifo_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // requests waiting for the driver, responses waiting for the monitor
    item_t pending_requests[$];
    resp_t expected_responses[$];

    int error_count       = 0;
    int accepted_requests = 0;
    int responses_seen    = 0;
    int size_settings     = 0;
    int status_counts [5] = '{default: 0};

    // ------------------------------------------------------------------
    // ring predictor: byte image plus pointers, updated per accepted request
    // ------------------------------------------------------------------
    logic [7:0]  ring_bytes [DEPTH] = '{default: 8'h00};
    int unsigned ring_len   = DEPTH;
    int unsigned rd_ptr     = 0;
    int unsigned wr_ptr     = 0;
    int unsigned commit_ptr = 0;
    int unsigned wr_left    = 0;
    int unsigned rd_left    = 0;

    function automatic int unsigned step_pos(input int unsigned p);
        return (p + 1 >= ring_len) ? 0 : p + 1;
    endfunction

    function automatic resp_t predict_response(input item_t it);
        resp_t            r;
        int unsigned      room;
        int unsigned      hdr_at;
        longint unsigned  stored;
        r.status = ST_OK;
        r.len    = '0;
        r.rbyte  = '0;
        r.last   = 1'b0;
        case (it.func)
            FN_WR_BEGIN: begin
                if (wr_left != 0) begin
                    r.status = ST_SEQ;
                end else begin
                    // one byte always stays free
                    room = (rd_ptr + ring_len - wr_ptr - 1) % ring_len;
                    if ((HDR_BYTES < 2 && it.length > 255) || HDR_BYTES + it.length > room) begin
                        r.status = ST_FULL;
                    end else begin
                        // little-endian length header
                        for (int i = 0; i < HDR_BYTES; i++) begin
                            ring_bytes[wr_ptr] = (i < 4) ? 8'(it.length >> (8 * i)) : 8'h00;
                            wr_ptr = step_pos(wr_ptr);
                        end
                        wr_left = it.length;
                        // empty message commits on its begin
                        if (it.length == 0) begin
                            commit_ptr = wr_ptr;
                            r.last     = 1'b1;
                        end
                    end
                end
            end
            FN_WR_DATA: begin
                if (wr_left == 0) begin
                    r.status = ST_SEQ;
                end else begin
                    ring_bytes[wr_ptr] = it.data_byte;
                    wr_ptr  = step_pos(wr_ptr);
                    wr_left = wr_left - 1;
                    if (wr_left == 0) begin
                        commit_ptr = wr_ptr;
                        r.last     = 1'b1;
                    end
                end
            end
            FN_RD_BEGIN: begin
                if (rd_left != 0) begin
                    r.status = ST_SEQ;
                end else if (rd_ptr == commit_ptr) begin
                    // nothing committed, open writes stay invisible
                    r.status = ST_EMPTY;
                end else begin
                    hdr_at = rd_ptr;
                    stored = 0;
                    for (int i = 0; i < HDR_BYTES; i++) begin
                        stored |= 64'(ring_bytes[rd_ptr]) << (8 * (i % 8));
                        rd_ptr = step_pos(rd_ptr);
                    end
                    r.len = 10'(stored);
                    if (stored > it.capacity) begin
                        // reader too small: message stays, header is not consumed
                        r.status = ST_TOO_SMALL;
                        rd_ptr   = hdr_at;
                    end else begin
                        rd_left = 32'(stored);
                        if (stored == 0) r.last = 1'b1;
                    end
                end
            end
            FN_RD_NEXT: begin
                if (rd_left == 0) begin
                    r.status = ST_SEQ;
                end else begin
                    r.rbyte = ring_bytes[rd_ptr];
                    rd_ptr  = step_pos(rd_ptr);
                    rd_left = rd_left - 1;
                    if (rd_left == 0) r.last = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus bookkeeping: occupancy and committed lengths, tracked as the
    // requests are queued so that sequences can be shaped ahead of time
    // ------------------------------------------------------------------
    int plan_ring     = DEPTH;
    int plan_used     = 0;
    int plan_wr_left  = 0;
    int plan_open_len = 0;
    int plan_rd_left  = 0;
    int plan_lens[$];

    function automatic void plan_request(input item_t it);
        int room;
        case (it.func)
            FN_WR_BEGIN: begin
                room = plan_ring - 1 - plan_used;
                if (plan_wr_left == 0 && HDR_BYTES + int'(it.length) <= room
                        && (HDR_BYTES >= 2 || it.length < 256)) begin
                    plan_used += HDR_BYTES;
                    if (it.length == 0) begin
                        plan_lens.push_back(0);
                    end else begin
                        plan_wr_left  = it.length;
                        plan_open_len = it.length;
                    end
                end
            end
            FN_WR_DATA: begin
                if (plan_wr_left != 0) begin
                    plan_used++;
                    plan_wr_left--;
                    if (plan_wr_left == 0) plan_lens.push_back(plan_open_len);
                end
            end
            FN_RD_BEGIN: begin
                if (plan_rd_left == 0 && plan_lens.size() != 0
                        && plan_lens[0] <= it.capacity) begin
                    plan_rd_left = plan_lens.pop_front();
                    plan_used   -= HDR_BYTES;
                end
            end
            FN_RD_NEXT: begin
                if (plan_rd_left != 0) begin
                    plan_rd_left--;
                    plan_used--;
                end
            end
        endcase
    endfunction

    task automatic queue_request(input func_t f, input int unsigned len,
                                 input int unsigned cap, input int unsigned dat);
        item_t it;
        it.func      = f;
        it.length    = 10'(len);
        it.capacity  = 10'(cap);
        it.data_byte = 8'(dat);
        plan_request(it);
        pending_requests.push_back(it);
    endtask

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued requests, predicts each one on acceptance
    // ------------------------------------------------------------------
    item_t drv_item;
    int    drv_gap    = 0;
    bit    drv_steady = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            drv_gap  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_responses.push_back(predict_response(drv_item));
                accepted_requests++;
                // occasionally switch between bursty and gappy sending
                if ($urandom_range(0, 31) == 0) drv_steady = !drv_steady;
                drv_gap = draw_wait(drv_steady);
            end
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    drv_item = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, drv_item.data_byte, drv_item.capacity, drv_item.length};
                    s_tuser  <= drv_item.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random ready stalls, one long hold-off, field checks
    // ------------------------------------------------------------------
    resp_t mon_want;
    int    rcv_wait   = 0;
    int    hold_left  = 0;
    bit    rcv_steady = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_wait  = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                responses_seen++;
                if (m_tuser <= ST_SEQ) status_counts[m_tuser]++;
                if (expected_responses.size() == 0) begin
                    report_error($sformatf("response %0d with no request outstanding",
                                           responses_seen));
                end else begin
                    mon_want = expected_responses.pop_front();
                    if (m_tuser != mon_want.status)
                        report_error($sformatf("response %0d status %0d, want %0d",
                                               responses_seen, m_tuser, mon_want.status));
                    if (m_tdata[9:0] != mon_want.len)
                        report_error($sformatf("response %0d length %0d, want %0d",
                                               responses_seen, m_tdata[9:0], mon_want.len));
                    if (m_tdata[17:10] != mon_want.rbyte)
                        report_error($sformatf("response %0d byte %02h, want %02h",
                                               responses_seen, m_tdata[17:10], mon_want.rbyte));
                    if (m_tlast != mon_want.last)
                        report_error($sformatf("response %0d last %0b, want %0b",
                                               responses_seen, m_tlast, mon_want.last));
                end
                if ($urandom_range(0, 31) == 0) rcv_steady = !rcv_steady;
                rcv_wait = draw_wait(rcv_steady);
                // one long back-pressure stretch so the unit fills and stalls its input
                if (responses_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
            end
            if (hold_left > 0) hold_left--;
            m_tready <= (rcv_wait == 0 && hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake means a hang
    // ------------------------------------------------------------------
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                 STALL_LIMIT, expected_responses.size());
        $display("FAIL length_prefixed_message_fifo_unit");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    // all requests answered, then idle time for the unit to settle
    task automatic await_idle();
        @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_responses.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // program the ring size; the unit empties the ring and closes transfers
    task automatic write_size(input int unsigned value);
        int clamped;
        clamped = value & 32'h7FF;
        if (clamped < MIN_RING) clamped = MIN_RING;
        if (clamped > DEPTH) clamped = DEPTH;
        await_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ring_len      = clamped;
        rd_ptr        = 0;
        wr_ptr        = 0;
        commit_ptr    = 0;
        wr_left       = 0;
        rd_left       = 0;
        plan_ring     = clamped;
        plan_used     = 0;
        plan_wr_left  = 0;
        plan_rd_left  = 0;
        plan_lens.delete();
        size_settings++;
    endtask

    // corner cases at the reset ring size
    task automatic directed_requests();
        queue_request(FN_RD_NEXT, 0, 0, 0);        // read byte with no read open
        queue_request(FN_WR_DATA, 0, 0, 8'h5A);    // data byte with no write open
        queue_request(FN_RD_BEGIN, 0, 1023, 0);    // empty ring
        queue_request(FN_WR_BEGIN, 0, 0, 0);       // zero-length message
        queue_request(FN_RD_BEGIN, 0, 0, 0);       // read it back, zero capacity
        queue_request(FN_WR_BEGIN, 3, 0, 0);
        queue_request(FN_WR_BEGIN, 5, 0, 0);       // begin while write open
        queue_request(FN_RD_BEGIN, 0, 1023, 0);    // open write is not visible yet
        queue_request(FN_WR_DATA, 0, 0, 8'h00);
        queue_request(FN_WR_DATA, 0, 0, 8'hFF);
        queue_request(FN_WR_DATA, 0, 0, 8'hA5);
        queue_request(FN_RD_BEGIN, 0, 2, 0);       // reader too small, message kept
        queue_request(FN_RD_BEGIN, 0, 1023, 0);
        queue_request(FN_RD_BEGIN, 0, 1023, 0);    // begin while read open
        queue_request(FN_RD_NEXT, 0, 0, 0);
        queue_request(FN_RD_NEXT, 0, 0, 0);
        queue_request(FN_RD_NEXT, 0, 0, 0);
        queue_request(FN_RD_NEXT, 0, 0, 0);        // past the end of the message
        queue_request(FN_WR_BEGIN, 1023, 0, 0);    // largest length, never fits
        queue_request(FN_WR_BEGIN, 1022, 0, 0);    // one byte more than free space
    endtask

    // mostly well-formed writes and reads with random content, some noise
    task automatic random_requests(input int count);
        int r;
        int pick;
        int want;
        int room;
        int len;
        int cap;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                queue_request(func_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 255));
            end else if (plan_wr_left != 0 && r < 60) begin
                queue_request(FN_WR_DATA, $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 255));
            end else if (plan_rd_left != 0 && r < 85) begin
                queue_request(FN_RD_NEXT, $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 255));
            end else if (plan_lens.size() != 0 && $urandom_range(0, 1) == 1) begin
                want = plan_lens[0];
                if (want > 0 && $urandom_range(0, 6) == 0) cap = $urandom_range(0, want - 1);
                else cap = $urandom_range(want, 1023);
                queue_request(FN_RD_BEGIN, $urandom_range(0, 1023), cap, $urandom_range(0, 255));
            end else begin
                // length room fits exactly; room + 1 and up is rejected as full
                room = plan_ring - 1 - plan_used - HDR_BYTES;
                pick = $urandom_range(0, 9);
                if (pick == 0) len = $urandom_range((room < 0) ? 0 : room + 1, 1023);
                else if (pick == 1 && room >= 0 && room <= 40) len = room;
                else if (pick == 2 && room >= -1 && room < 1023) len = room + 1;
                else len = $urandom_range(0, 12);
                queue_request(FN_WR_BEGIN, len, $urandom_range(0, 1023), $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset ring size first, then minimum, clamped and random sizes
        directed_requests();
        random_requests(100);
        write_size(MIN_RING);
        random_requests(130);
        write_size($urandom_range(MIN_RING + 1, 100));
        random_requests(100);
        write_size(0);                 // below the minimum, acts as 16
        random_requests(40);
        write_size(2047);              // above DEPTH, acts as DEPTH
        random_requests(60);
        write_size(DEPTH);
        random_requests(70);

        await_idle();
        if (expected_responses.size() != 0)
            report_error($sformatf("%0d responses never arrived", expected_responses.size()));

        $display("run covered %0d requests and %0d responses over %0d programmed ring sizes",
                 accepted_requests, responses_seen, size_settings);
        $display("responses by status: ok %0d, full %0d, empty %0d, too_small %0d, sequence %0d",
                 status_counts[ST_OK], status_counts[ST_FULL], status_counts[ST_EMPTY],
                 status_counts[ST_TOO_SMALL], status_counts[ST_SEQ]);
        if (error_count == 0) begin
            $display("PASS length_prefixed_message_fifo_unit");
        end else begin
            $display("FAIL length_prefixed_message_fifo_unit");
        end
        $finish;
    end

endmodule
